### hdl/assert_macros.svh
// assertion macros shared by the detector modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define FEVAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define FEVAD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/fevad_pkg.sv
// shared constants and types of the frame energy voice activity detector
package fevad_pkg;

  // parameter defaults
  localparam int FRAME_SAMPLES_DEF = 320;
  localparam int FRAME_MS_DEF      = 20;
  localparam int COUNT_BITS_DEF    = 24;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 32;
  localparam int SUM_W       = 40;
  localparam int RMS_W       = 16;
  localparam int CNT_FIELD_W = 24;
  localparam int RATIO_W     = 17;
  localparam int RATIO_FRAC  = 16;
  localparam int MS_W        = 16;

  // result limits
  localparam logic [CNT_FIELD_W-1:0] CNT_FIELD_MAX = '1;
  localparam logic [RMS_W-1:0]       MEAN_MAX      = 16'd32768;
  localparam logic [RATIO_W-1:0]     RATIO_MAX     = 17'd65536;

  // integer square root: radicand width and first trial bit
  localparam int              ROOT_W     = 32;
  localparam logic [ROOT_W-1:0] ROOT_START = 32'h4000_0000;

  // frame queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RMS_THRESHOLD = 2'd0,
    CFG_MIN_SPEECH_MS = 2'd1,
    CFG_VAD_ENABLED   = 2'd2
  } cfg_idx_e;

  localparam logic [RMS_W-1:0] RMS_THRESHOLD_RST = 16'd328;
  localparam logic [MS_W-1:0]  MIN_SPEECH_MS_RST = 16'd200;
  localparam logic             VAD_ENABLED_RST   = 1'b1;

  // live configuration handed to the back end
  typedef struct packed {
    logic [RMS_W-1:0] rms_threshold;
    logic [MS_W-1:0]  min_speech_ms;
    logic             skip_en;
  } cfg_t;

endpackage

### hdl/fevad_ifs.sv
// channel interfaces: samples in, summary out, register writes

interface fevad_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fevad_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface fevad_result_if;
  logic                              valid;
  logic                              ready;
  logic                              speech_present;
  logic                              skip;
  logic [fevad_pkg::CNT_FIELD_W-1:0] speech_frame_count;
  logic [fevad_pkg::CNT_FIELD_W-1:0] frame_count;
  logic [fevad_pkg::RMS_W-1:0]       mean_rms;
  logic [fevad_pkg::RATIO_W-1:0]     speech_share;

  modport source (output valid, output speech_present, output skip,
                  output speech_frame_count, output frame_count, output mean_rms,
                  output speech_share, input ready);
  modport sink   (input valid, input speech_present, input skip,
                  input speech_frame_count, input frame_count, input mean_rms,
                  input speech_share, output ready);
endinterface

interface fevad_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fevad_pkg::CFG_IDX_W-1:0]  index;
  logic [fevad_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/frame_energy_voice_activity_detector.sv
// Frame energy voice activity detector, top level. Signed samples of one recording enter one
// per cycle on in_i, the final one flagged by last; they are squared and summed per frame of
// FRAME_SAMPLES, and each closed frame goes through a two-entry queue to the back end, which
// takes the frame mean by the shared one-bit-per-cycle divider, its integer root and updates
// the frame counters. Samples are taken at one per cycle whenever the queue has room; with
// short frames the back end sets the rate. After the last sample two further divisions (mean
// rms and speech ratio) run before the single summary transaction appears on out_o, where it
// is held until taken while the front goes on accepting the next recording as long as the
// queue has room. Register writes on cfg_i (threshold, minimum speech time, skip enable) are
// always accepted and must be made while the block is idle.
module frame_energy_voice_activity_detector #(
  parameter int FRAME_SAMPLES = fevad_pkg::FRAME_SAMPLES_DEF,
  parameter int FRAME_MS      = fevad_pkg::FRAME_MS_DEF,
  parameter int COUNT_BITS    = fevad_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fevad_sample_if.sink    in_i,
  fevad_result_if.source  out_o,
  fevad_cfg_if.sink       cfg_i
);

  localparam int LEN_W  = $clog2(FRAME_SAMPLES + 1);
  localparam int JOB_W  = fevad_pkg::SUM_W + LEN_W + 1;
  localparam int RAT_W  = COUNT_BITS + fevad_pkg::RATIO_FRAC;
  localparam int DVD_W  = (RAT_W > fevad_pkg::SUM_W) ? RAT_W : fevad_pkg::SUM_W;
  localparam int DVS_W  = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  fevad_pkg::cfg_t  cfg_q;
  logic             push;
  logic             full;
  logic [JOB_W-1:0] job_in;
  logic             pop;
  logic             job_valid;
  logic [JOB_W-1:0] job_out;

  // configuration registers, unknown indexes ignored
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rms_threshold <= fevad_pkg::RMS_THRESHOLD_RST;
      cfg_q.min_speech_ms <= fevad_pkg::MIN_SPEECH_MS_RST;
      cfg_q.skip_en       <= fevad_pkg::VAD_ENABLED_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        fevad_pkg::CFG_RMS_THRESHOLD: cfg_q.rms_threshold <= cfg_i.data;
        fevad_pkg::CFG_MIN_SPEECH_MS: cfg_q.min_speech_ms <= cfg_i.data;
        fevad_pkg::CFG_VAD_ENABLED:   cfg_q.skip_en       <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // sample accumulation
  fevad_front #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .LEN_W         (LEN_W)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  // closed frame queue
  fevad_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (fevad_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  // frame rms and summary
  fevad_back #(
    .FRAME_MS   (FRAME_MS),
    .COUNT_BITS (COUNT_BITS),
    .LEN_W      (LEN_W),
    .DVD_W      (DVD_W),
    .DVS_W      (DVS_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .res_o       (out_o)
  );

endmodule

### hdl/fevad_front.sv
// front end: squares samples, sums them per frame and queues closed frames
`include "assert_macros.svh"

module fevad_front #(
  parameter int FRAME_SAMPLES = fevad_pkg::FRAME_SAMPLES_DEF,
  parameter int LEN_W         = $clog2(fevad_pkg::FRAME_SAMPLES_DEF + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  fevad_sample_if.sink                          in_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output logic [fevad_pkg::SUM_W+LEN_W:0]       job_o
);

  localparam int FILL_W = $clog2(FRAME_SAMPLES);

  logic [FILL_W-1:0]              fill_q;
  logic [fevad_pkg::SUM_W-1:0]    sum_q;
  logic                           s2_valid_q;
  logic [fevad_pkg::SQ_W-1:0]     sq_q;
  logic [LEN_W-1:0]               len_q;
  logic                           last_q;
  logic                           close_q;

  logic [fevad_pkg::SAMPLE_W-1:0] raw;
  logic [fevad_pkg::SAMPLE_W-1:0] mag;
  logic [fevad_pkg::SQ_W-1:0]     sq;
  logic [LEN_W-1:0]               len_in;
  logic                           close_in;
  logic                           accept;
  logic                           s2_go;
  logic [fevad_pkg::SUM_W-1:0]    sum_new;

  // magnitude and square of the incoming sample
  assign raw = in_i.sample;
  assign mag = raw[fevad_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;
  assign sq  = fevad_pkg::SQ_W'(mag) * fevad_pkg::SQ_W'(mag);

  // frame boundary decided on entry
  assign len_in   = LEN_W'(fill_q) + LEN_W'(1);
  assign close_in = (len_in >= LEN_W'(FRAME_SAMPLES)) || in_i.last;

  // second stage adds the square, stalls only on a full queue at frame end
  assign s2_go      = s2_valid_q && (!close_q || !full_i);
  assign in_i.ready = !s2_valid_q || s2_go;
  assign accept     = in_i.valid && in_i.ready;
  assign sum_new    = sum_q + fevad_pkg::SUM_W'(sq_q);

  assign push_o = s2_go && close_q;
  assign job_o  = {last_q, len_q, sum_new};

  // sample register and frame accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      sum_q      <= '0;
      s2_valid_q <= 1'b0;
      sq_q       <= '0;
      len_q      <= '0;
      last_q     <= 1'b0;
      close_q    <= 1'b0;
    end else begin
      if (accept) begin
        sq_q       <= sq;
        len_q      <= len_in;
        last_q     <= in_i.last;
        close_q    <= close_in;
        fill_q     <= close_in ? '0 : FILL_W'(len_in);
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_go) begin
        sum_q <= close_q ? '0 : sum_new;
      end
    end
  end

  `FEVAD_ASSERT(a_fill_in_frame, fill_q < FILL_W'(FRAME_SAMPLES - 1) || fill_q == FILL_W'(FRAME_SAMPLES - 1), "frame fill beyond frame length")
  `FEVAD_ASSERT(a_short_close_only_last, (s2_valid_q && close_q && len_q != LEN_W'(FRAME_SAMPLES)) |-> last_q, "short frame closed without last sample")

endmodule

### hdl/fevad_fifo.sv
// short queue of closed frames between front and back
`include "assert_macros.svh"

module fevad_fifo #(
  parameter int DATA_W = 51,
  parameter int DEPTH  = fevad_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  `FEVAD_NEVER(a_no_push_when_full, push_i && full_o, "frame pushed into a full queue")

endmodule

### hdl/fevad_div.sv
// shared restoring divider, one quotient bit per cycle
module fevad_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             fits;

  // one trial subtraction
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[DVD_W-2:0], fits};
        rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/fevad_back.sv
// back end: frame rms by divide and root, frame counters and recording summary
`include "assert_macros.svh"

module fevad_back #(
  parameter int FRAME_MS   = fevad_pkg::FRAME_MS_DEF,
  parameter int COUNT_BITS = fevad_pkg::COUNT_BITS_DEF,
  parameter int LEN_W      = $clog2(fevad_pkg::FRAME_SAMPLES_DEF + 1),
  parameter int DVD_W      = 40,
  parameter int DVS_W      = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fevad_pkg::cfg_t                 cfg_i,
  input  logic                            job_valid_i,
  input  logic [fevad_pkg::SUM_W+LEN_W:0] job_i,
  output logic                            pop_o,
  fevad_result_if.source                  res_o
);

  localparam int SUM_W     = fevad_pkg::SUM_W;
  localparam int RMS_W     = fevad_pkg::RMS_W;
  localparam int ROOT_W    = fevad_pkg::ROOT_W;
  localparam int FLD_W     = fevad_pkg::CNT_FIELD_W;
  localparam int MSM_W     = $clog2(FRAME_MS + 1);
  localparam int PROD_W    = COUNT_BITS + MSM_W;
  localparam int CMP_W     = (PROD_W > fevad_pkg::MS_W) ? PROD_W : fevad_pkg::MS_W;
  localparam int CNT_EXT_W = (COUNT_BITS > FLD_W) ? COUNT_BITS : FLD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FDIV,
    S_ROOT,
    S_ACC,
    S_MSTART,
    S_MDIV,
    S_RDIV,
    S_OUT
  } state_e;

  state_e                        state_q;
  logic                          last_q;
  logic [ROOT_W-1:0]             v_q;
  logic [ROOT_W-1:0]             res_q;
  logic [ROOT_W-1:0]             bit_q;
  logic [COUNT_BITS-1:0]         speech_q;
  logic [COUNT_BITS-1:0]         total_q;
  logic [SUM_W-1:0]              rms_total_q;
  logic [RMS_W-1:0]              mean_q;
  logic                          out_valid_q;
  logic                          has_q;
  logic                          skip_q;
  logic [FLD_W-1:0]              sc_q;
  logic [FLD_W-1:0]              fc_q;
  logic [RMS_W-1:0]              mean_out_q;
  logic [fevad_pkg::RATIO_W-1:0] ratio_q;

  logic                          div_start;
  logic [DVD_W-1:0]              div_dvd;
  logic [DVS_W-1:0]              div_dvs;
  logic                          div_busy;
  logic                          div_done;
  logic [DVD_W-1:0]              div_quo;

  logic [SUM_W-1:0]              job_sum;
  logic [LEN_W-1:0]              job_len;
  logic                          job_last;
  logic [ROOT_W-1:0]             trial;
  logic [RMS_W-1:0]              rms;
  logic [SUM_W:0]                rms_sum;
  logic [PROD_W-1:0]             speech_ms;
  logic                          min_met;
  logic [CNT_EXT_W-1:0]          speech_ext;
  logic [CNT_EXT_W-1:0]          total_ext;

  // unpack the queued frame
  assign job_sum  = job_i[SUM_W-1:0];
  assign job_len  = job_i[SUM_W +: LEN_W];
  assign job_last = job_i[SUM_W+LEN_W];
  assign pop_o    = (state_q == S_IDLE) && job_valid_i;

  // divider operand selection
  assign div_start = pop_o || (state_q == S_MSTART) || ((state_q == S_MDIV) && div_done);
  always_comb begin
    case (state_q)
      S_IDLE: begin
        div_dvd = DVD_W'(job_sum);
        div_dvs = DVS_W'(job_len);
      end
      S_MSTART: begin
        div_dvd = DVD_W'(rms_total_q);
        div_dvs = DVS_W'(total_q);
      end
      default: begin
        div_dvd = DVD_W'({speech_q, {fevad_pkg::RATIO_FRAC{1'b0}}});
        div_dvs = DVS_W'(total_q);
      end
    endcase
  end

  fevad_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // root step, rms accumulation and speech duration test
  assign trial      = res_q + bit_q;
  assign rms        = res_q[RMS_W-1:0];
  assign rms_sum    = {1'b0, rms_total_q} + (SUM_W + 1)'(rms);
  assign speech_ms  = PROD_W'(speech_q) * PROD_W'(FRAME_MS);
  assign min_met    = (CMP_W'(speech_ms) >= CMP_W'(cfg_i.min_speech_ms));
  assign speech_ext = CNT_EXT_W'(speech_q);
  assign total_ext  = CNT_EXT_W'(total_q);

  // result channel
  assign res_o.valid              = out_valid_q;
  assign res_o.speech_present     = has_q;
  assign res_o.skip               = skip_q;
  assign res_o.speech_frame_count = sc_q;
  assign res_o.frame_count        = fc_q;
  assign res_o.mean_rms           = mean_out_q;
  assign res_o.speech_share       = ratio_q;

  // sequencer with accumulators and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      v_q         <= '0;
      res_q       <= '0;
      bit_q       <= '0;
      speech_q    <= '0;
      total_q     <= '0;
      rms_total_q <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
      has_q       <= 1'b0;
      skip_q      <= 1'b0;
      sc_q        <= '0;
      fc_q        <= '0;
      mean_out_q  <= '0;
      ratio_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            last_q  <= job_last;
            state_q <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            v_q     <= div_quo[ROOT_W-1:0];
            res_q   <= '0;
            bit_q   <= fevad_pkg::ROOT_START;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (v_q >= trial) begin
            v_q   <= v_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == ROOT_W'(1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          rms_total_q <= rms_sum[SUM_W] ? '1 : rms_sum[SUM_W-1:0];
          if (total_q != '1) begin
            total_q <= total_q + COUNT_BITS'(1);
          end
          if (rms >= cfg_i.rms_threshold && speech_q != '1) begin
            speech_q <= speech_q + COUNT_BITS'(1);
          end
          state_q <= last_q ? S_MSTART : S_IDLE;
        end
        S_MSTART: begin
          state_q <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            mean_q  <= (div_quo > DVD_W'(fevad_pkg::MEAN_MAX)) ? fevad_pkg::MEAN_MAX
                                                               : div_quo[RMS_W-1:0];
            state_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            ratio_q     <= (div_quo > DVD_W'(fevad_pkg::RATIO_MAX))
                           ? fevad_pkg::RATIO_MAX : div_quo[fevad_pkg::RATIO_W-1:0];
            has_q       <= min_met;
            skip_q      <= cfg_i.skip_en && !min_met;
            sc_q        <= (speech_ext > CNT_EXT_W'(fevad_pkg::CNT_FIELD_MAX))
                           ? fevad_pkg::CNT_FIELD_MAX : speech_ext[FLD_W-1:0];
            fc_q        <= (total_ext > CNT_EXT_W'(fevad_pkg::CNT_FIELD_MAX))
                           ? fevad_pkg::CNT_FIELD_MAX : total_ext[FLD_W-1:0];
            mean_out_q  <= mean_q;
            out_valid_q <= 1'b1;
            speech_q    <= '0;
            total_q     <= '0;
            rms_total_q <= '0;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `FEVAD_NEVER(a_div_start_busy, div_start && div_busy, "divider started while busy")
  `FEVAD_ASSERT(a_speech_le_total, speech_q <= total_q, "more speech frames than frames")
  `FEVAD_ASSERT(a_result_only_in_out, out_valid_q |-> (state_q == S_OUT), "result shown outside output state")

endmodule
